// ===== rtl/kcd_pkg.sv =====
// Package for the key click / double click / long press detector.
// Types, widths and action codes shared by the lanes, the merge stage and the top level.
// No dependencies.
`default_nettype none

package kcd_pkg;

  localparam int PIN_W  = 3;   // pin_levels field
  localparam int IDX_W  = 2;   // key_index field
  localparam int ACT_W  = 2;   // key_action field
  localparam int TICK_W = 8;   // tick limit registers
  localparam int CNT_W  = 9;   // hold and gap counters
  localparam int CFG_IDX_W = 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 2'd0,
    ACT_CLICK  = 2'd1,
    ACT_DOUBLE = 2'd2,
    ACT_LONG   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS   = 1'b0,
    REG_DOUBLE_CLICK = 1'b1
  } cfg_reg_t;

  // tick limits as seen by every lane
  typedef struct packed {
    logic [TICK_W-1:0] long_press_ticks;
    logic [TICK_W-1:0] double_click_ticks;
  } tick_cfg_t;

  // per-lane strobe group for one accepted beat
  typedef struct packed {
    logic scan;     // scan beat accepted
    logic down;     // this key's pin reads pressed
    logic rd_clr;   // read beat addressed to this key
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/kcd_lane.sv =====
// One key lane: press / gap counting and pending action for a single key.
// Depends on kcd_pkg.
`default_nettype none

module kcd_lane
  import kcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire tick_cfg_t  cfg,
  input  wire lane_ctrl_t ctrl,
  output action_t         pending
);

  logic             pressed_r, pressed_nxt;
  action_t          pend_r, pend_nxt;
  logic [CNT_W-1:0] hold_r, hold_nxt;
  logic [CNT_W-1:0] gap_r, gap_nxt;
  logic [CNT_W-1:0] gap_inc;
  logic             dbl_r, dbl_nxt;
  logic             long_r, long_nxt;

  assign gap_inc = gap_r + CNT_W'(1);

  always_comb begin
    pressed_nxt = pressed_r;
    pend_nxt    = pend_r;
    hold_nxt    = hold_r;
    gap_nxt     = gap_r;
    dbl_nxt     = dbl_r;
    long_nxt    = long_r;
    if (ctrl.scan) begin
      if (ctrl.down) begin
        if (hold_r <= {1'b0, cfg.long_press_ticks}) begin
          pressed_nxt = 1'b1;
          hold_nxt    = hold_r + CNT_W'(1);
          if (gap_r != '0) begin
            dbl_nxt = 1'b1;
            gap_nxt = '0;
          end
        end else begin
          pend_nxt = ACT_LONG;
          long_nxt = 1'b1;
        end
      end else if (pressed_r && !dbl_r && !long_r) begin
        hold_nxt = '0;
        if (gap_inc > {1'b0, cfg.double_click_ticks}) begin
          pend_nxt    = ACT_CLICK;
          pressed_nxt = 1'b0;
          gap_nxt     = '0;
        end else begin
          gap_nxt = gap_inc;
        end
      end else begin
        // release: a marked double click is posted, but a long press wins and clears the pending action to none
        if (dbl_r) begin
          pend_nxt = ACT_DOUBLE;
          dbl_nxt  = 1'b0;
        end
        if (long_r) begin
          long_nxt = 1'b0;
          pend_nxt = ACT_NONE;
        end
        pressed_nxt = 1'b0;
        hold_nxt    = '0;
      end
    end else if (ctrl.rd_clr) begin
      if (pend_r == ACT_CLICK || pend_r == ACT_DOUBLE) begin
        pend_nxt = ACT_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      pend_r    <= ACT_NONE;
      hold_r    <= '0;
      gap_r     <= '0;
      dbl_r     <= 1'b0;
      long_r    <= 1'b0;
    end else begin
      pressed_r <= pressed_nxt;
      pend_r    <= pend_nxt;
      hold_r    <= hold_nxt;
      gap_r     <= gap_nxt;
      dbl_r     <= dbl_nxt;
      long_r    <= long_nxt;
    end
  end

  assign pending = pend_r;

endmodule

`default_nettype wire

// ===== rtl/kcd_merge.sv =====
// Merge stage: picks the addressed lane's action on a read beat and holds it
// in an output register backed by a skid register. Depends on kcd_pkg.
`default_nettype none

module kcd_merge
  import kcd_pkg::*;
#(
  parameter int NUM_KEYS = 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,      // read beat accepted
  input  wire logic [IDX_W-1:0]             key_index,
  input  wire logic [NUM_KEYS-1:0][ACT_W-1:0] pend,
  output logic                              full,      // skid occupied
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output action_t                           out_action
);

  action_t sel;
  logic    out_valid_r, out_valid_nxt;
  action_t out_r, out_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  action_t skid_r, skid_nxt;

  // out-of-range index matches no lane and reads as none
  always_comb begin
    sel = ACT_NONE;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (32'(key_index) == k) begin
        sel = action_t'(pend[k]);
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_nxt       = sel;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign full       = skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_action = out_r;

endmodule

`default_nettype wire

// ===== rtl/key_click_double_long_detector_core.sv =====
// Top level of the key click / double click / long press detector.
// Depends on kcd_pkg, kcd_lane and kcd_merge.
`default_nettype none

// Tracks NUM_KEYS active-low keys, one lane each. A beat with tuser = 0 is a
// scan tick: every lane samples its pin bit (keys beyond the three pin bits
// read as pressed) and advances its hold and gap counters. A beat with
// tuser = 1 reads one key's pending action and returns one result beat;
// click and double click are cleared by the read, long press stays until the
// key is released. A read of a key index at or above NUM_KEYS returns none.
// The block takes one beat per clock while in_tready is high: every lane
// updates in the accepting cycle, and the merge stage registers the
// selected action. Results wait in an output register plus a skid
// register; in_tready falls only while both are occupied. Tick limits are
// written through the cfg port (index 0: long press, index 1: double click
// gap), which is always ready and is meant to be written while idle.
module key_click_double_long_detector_core
  import kcd_pkg::*;
#(
  parameter int NUM_KEYS = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // scan / read beats
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [2:0] pin_levels, [4:3] key_index
  input  wire logic                 in_tuser,   // [0] mode
  // result beats
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_tdata,  // [1:0] key_action
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TICK_W-1:0]    cfg_data
);

  logic                         in_acc;
  logic                         full;
  logic [PIN_W-1:0]             pins;
  logic [IDX_W-1:0]             key_index;
  tick_cfg_t                    cfg_r, cfg_nxt;
  logic [NUM_KEYS-1:0][ACT_W-1:0] pend;
  action_t                      out_action;

  assign in_tready = !full;
  assign in_acc    = in_tvalid && in_tready;
  assign pins      = in_tdata[PIN_W-1:0];
  assign key_index = in_tdata[PIN_W +: IDX_W];

  // tick limit registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LONG_PRESS:   cfg_nxt.long_press_ticks   = cfg_data;
        REG_DOUBLE_CLICK: cfg_nxt.double_click_ticks = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks   <= TICK_W'(25);
      cfg_r.double_click_ticks <= TICK_W'(5);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // one lane per key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    lane_ctrl_t ctrl;
    action_t    lane_pend;

    always_comb begin
      ctrl.scan   = in_acc && !in_tuser;
      ctrl.down   = (k < PIN_W) ? !pins[k % PIN_W] : 1'b1;
      ctrl.rd_clr = in_acc && in_tuser && (32'(key_index) == k);
    end

    kcd_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .cfg     (cfg_r),
      .ctrl    (ctrl),
      .pending (lane_pend)
    );

    assign pend[k] = lane_pend;
  end

  kcd_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_acc && in_tuser),
    .key_index  (key_index),
    .pend       (pend),
    .full       (full),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_action (out_action)
  );

  assign out_tdata = {{(8 - ACT_W){1'b0}}, out_action};

endmodule

`default_nettype wire
